// File: rtl/axis_calibration_mapper_assert.svh
// Assertion macros shared by the calibration mapper RTL.
`ifndef AXIS_CALIBRATION_MAPPER_ASSERT_SVH
`define AXIS_CALIBRATION_MAPPER_ASSERT_SVH

// Condition must hold whenever out of reset.
`define ACM_ASSERT_ON(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("acm: check failed");

// Same-cycle implication.
`define ACM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acm: implication failed");

// Next-cycle implication.
`define ACM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acm: next-cycle implication failed");

`endif

// File: rtl/acm_pkg.sv
// Shared types and constants of the axis calibration mapper.
`default_nettype none
package acm_pkg;

    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_CENTER = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MAX    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEAD_BAND    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EXPO_PERCENT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INVERT       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LINEAR       = 3'd6;

    localparam int MIN_RESET  = 200;
    localparam int BAND_RESET = 20;

    localparam logic [6:0]  EXPO_FULL = 7'd100;
    localparam logic [15:0] AXIS_MID  = 16'd32768;
    localparam logic [15:0] K_LINEAR  = 16'd65535;
    localparam logic [15:0] K_UP      = 16'd32767;
    localparam logic [15:0] K_DOWN    = 16'd32768;

    typedef struct packed {
        logic [6:0] expo_percent;
        logic       invert_output;
        logic       linear_mode;
    } t_mode;

endpackage
`default_nettype wire

// File: rtl/acm_ifs.sv
// Valid/ready stream interfaces for raw samples and mapped axis values.
`default_nettype none
interface acm_sample_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_sample;
    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface acm_value_if;
    logic        valid;
    logic        ready;
    logic [15:0] axis_value;
    modport source (output valid, output axis_value, input ready);
    modport sink   (input valid, input axis_value, output ready);
endinterface
`default_nettype wire

// File: rtl/axis_calibration_mapper.sv
// Throughput: one sample per cycle while the output is not stalled; the divider resolves one quotient bit per stage.
// Each stage stalls on its own, so bubbles fill while a result waits at the output.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
// Registers are read at several stages, so write them only with no sample in flight.
`default_nettype none
`include "axis_calibration_mapper_assert.svh"
module axis_calibration_mapper import acm_pkg::*; #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    acm_sample_if.sink              i_sample,
    acm_value_if.source             o_result
);
    localparam int SW = SAMPLE_BITS;
    localparam int FB = FRACTION_BITS;
    localparam logic [SW-1:0] RST_MIN    = SW'(MIN_RESET);
    localparam logic [SW-1:0] RST_CENTER = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] RST_MAX    = ~SW'(MIN_RESET);
    localparam logic [SW-1:0] RST_BAND   = SW'(BAND_RESET);

    logic [SW-1:0]          r_range_min, r_range_center, r_range_max, r_dead_band;
    logic [6:0]             r_expo;
    logic                   r_invert, r_linear;
    t_mode                  mode;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    logic                   fr_valid, fr_ready, fr_sat, fr_up;
    logic [SW-1:0]          fr_num, fr_den;
    logic                   dv_valid, dv_ready, dv_up;
    logic [FB:0]            dv_f;
    logic                   ex_valid, ex_ready, ex_up;
    logic [FB:0]            ex_g;

    logic [2:0]             go;
    logic [1:0]             r_vld;
    logic [15:0]            k_sel, r_scaled, r_axis;
    logic [FB+16:0]         scale_prod;
    logic                   r_up_o;
    logic [16:0]            sum;
    logic [15:0]            n_axis;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign mode    = '{expo_percent: r_expo, invert_output: r_invert, linear_mode: r_linear};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min    <= RST_MIN;
            r_range_center <= RST_CENTER;
            r_range_max    <= RST_MAX;
            r_dead_band    <= RST_BAND;
            r_expo         <= '0;
            r_invert       <= 1'b0;
            r_linear       <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RANGE_MIN:    r_range_min    <= pwdata[SW-1:0];
                REG_RANGE_CENTER: r_range_center <= pwdata[SW-1:0];
                REG_RANGE_MAX:    r_range_max    <= pwdata[SW-1:0];
                REG_DEAD_BAND:    r_dead_band    <= pwdata[SW-1:0];
                REG_EXPO_PERCENT: r_expo         <= pwdata[6:0];
                REG_INVERT:       r_invert       <= pwdata[0];
                REG_LINEAR:       r_linear       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RANGE_MIN:    prdata = 32'(r_range_min);
            REG_RANGE_CENTER: prdata = 32'(r_range_center);
            REG_RANGE_MAX:    prdata = 32'(r_range_max);
            REG_DEAD_BAND:    prdata = 32'(r_dead_band);
            REG_EXPO_PERCENT: prdata = 32'(r_expo);
            REG_INVERT:       prdata = 32'(r_invert);
            REG_LINEAR:       prdata = 32'(r_linear);
            default:          prdata = '0;
        endcase
    end

    acm_front #(.SAMPLE_BITS(SW)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (mode),
        .i_range_min    (r_range_min),
        .i_range_center (r_range_center),
        .i_range_max    (r_range_max),
        .i_dead_band    (r_dead_band),
        .i_valid        (i_sample.valid),
        .o_ready        (i_sample.ready),
        .i_raw_sample   (i_sample.raw_sample),
        .o_valid        (fr_valid),
        .i_ready        (fr_ready),
        .o_num          (fr_num),
        .o_den          (fr_den),
        .o_sat          (fr_sat),
        .o_up           (fr_up)
    );

    acm_div #(.SAMPLE_BITS(SW), .FRACTION_BITS(FB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_num   (fr_num),
        .i_den   (fr_den),
        .i_sat   (fr_sat),
        .i_up    (fr_up),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_f     (dv_f),
        .o_up    (dv_up)
    );

    acm_expo #(.FRACTION_BITS(FB)) u_expo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (mode),
        .i_valid (dv_valid),
        .o_ready (dv_ready),
        .i_f     (dv_f),
        .i_up    (dv_up),
        .o_valid (ex_valid),
        .i_ready (ex_ready),
        .o_g     (ex_g),
        .o_up    (ex_up)
    );

    assign go[2]    = o_result.ready;
    assign go[1]    = !r_vld[1] || go[2];
    assign go[0]    = !r_vld[0] || go[1];
    assign ex_ready = go[0];

    always_comb begin
        if (r_linear) begin
            k_sel = K_LINEAR;
        end else if (ex_up) begin
            k_sel = K_UP;
        end else begin
            k_sel = K_DOWN;
        end
        scale_prod = (FB+17)'(ex_g) * (FB+17)'(k_sel);
        if (r_linear) begin
            sum = {1'b0, r_scaled};
        end else if (r_up_o) begin
            sum = {1'b0, AXIS_MID} + {1'b0, r_scaled};
        end else begin
            sum = {1'b0, AXIS_MID} - {1'b0, r_scaled};
        end
        n_axis = r_invert ? ~sum[15:0] : sum[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (go[0]) r_vld[0] <= ex_valid;
            if (go[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_scaled <= scale_prod[FB+15:FB];
            r_up_o   <= ex_up;
        end
        if (go[1]) begin
            r_axis <= n_axis;
        end
    end

    assign o_result.valid      = r_vld[1];
    assign o_result.axis_value = r_axis;

    `ACM_ASSERT_NXT(a_scale_hold, i_clk, i_rst_n, r_vld[0] && !go[1], r_vld[0])

endmodule
`default_nettype wire

// File: rtl/acm_front.sv
// Front stages: offset, span and dead band to numerator and divisor.
`default_nettype none
`include "axis_calibration_mapper_assert.svh"
module acm_front import acm_pkg::*; #(
    parameter int SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_mode                  i_mode,
    input  wire logic [SAMPLE_BITS-1:0] i_range_min,
    input  wire logic [SAMPLE_BITS-1:0] i_range_center,
    input  wire logic [SAMPLE_BITS-1:0] i_range_max,
    input  wire logic [SAMPLE_BITS-1:0] i_dead_band,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_raw_sample,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_BITS-1:0]      o_num,
    output logic [SAMPLE_BITS-1:0]      o_den,
    output logic                        o_sat,
    output logic                        o_up
);
    localparam int SW = SAMPLE_BITS;

    logic [2:0]    go;
    logic [1:0]    r_vld;
    logic [SW:0]   d_lin, d_ctr, d_neg, span_raw, n_off;
    logic          n_up1;
    logic [SW-1:0] n_span;
    logic [SW:0]   r_off;
    logic [SW-1:0] r_span;
    logic          r_up1;
    logic [SW:0]   off_db, span_db;
    logic [SW-1:0] n_num, n_den;
    logic          n_sat;
    logic [SW-1:0] r_num, r_den;
    logic          r_sat, r_up2;

    assign go[2]   = i_ready;
    assign go[1]   = !r_vld[1] || go[2];
    assign go[0]   = !r_vld[0] || go[1];
    assign o_ready = go[0];

    always_comb begin
        d_lin = {1'b0, i_raw_sample} - {1'b0, i_range_min};
        d_ctr = {1'b0, i_raw_sample} - {1'b0, i_range_center};
        d_neg = {1'b0, i_range_center} - {1'b0, i_raw_sample};
        n_up1 = ~d_ctr[SW];
        if (i_mode.linear_mode) begin
            span_raw = {1'b0, i_range_max} - {1'b0, i_range_min};
            n_off    = d_lin;
        end else if (n_up1) begin
            span_raw = {1'b0, i_range_max} - {1'b0, i_range_center};
            n_off    = d_ctr;
        end else begin
            span_raw = {1'b0, i_range_center} - {1'b0, i_range_min};
            n_off    = d_neg;
        end
        if (span_raw[SW] || span_raw == '0) begin
            n_span = SW'(1);
        end else begin
            n_span = span_raw[SW-1:0];
        end
    end

    always_comb begin
        off_db  = r_off - {1'b0, i_dead_band};
        span_db = {1'b0, r_span} - {1'b0, i_dead_band};
        if (i_mode.linear_mode) begin
            n_den = r_span;
            if (r_off[SW]) begin
                n_num = '0;
            end else if (r_off[SW-1:0] >= r_span) begin
                n_num = r_span;
            end else begin
                n_num = r_off[SW-1:0];
            end
        end else begin
            n_num = off_db[SW] ? '0 : off_db[SW-1:0];
            n_den = (span_db[SW] || span_db == '0) ? SW'(1) : span_db[SW-1:0];
        end
        n_sat = n_num >= n_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (go[0]) r_vld[0] <= i_valid;
            if (go[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_off  <= n_off;
            r_span <= n_span;
            r_up1  <= n_up1;
        end
        if (go[1]) begin
            r_num <= n_sat ? '0 : n_num;
            r_den <= n_den;
            r_sat <= n_sat;
            r_up2 <= r_up1;
        end
    end

    assign o_valid = r_vld[1];
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_sat   = r_sat;
    assign o_up    = r_up2;

    `ACM_ASSERT_IMP(a_den_nonzero, i_clk, i_rst_n, r_vld[1], r_den != '0)

endmodule
`default_nettype wire

// File: rtl/acm_div.sv
// Pipelined restoring divider: one quotient bit per stage, capped at 1.0.
`default_nettype none
`include "axis_calibration_mapper_assert.svh"
module acm_div #(
    parameter int SAMPLE_BITS,
    parameter int FRACTION_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [SAMPLE_BITS-1:0]   i_num,
    input  wire logic [SAMPLE_BITS-1:0]   i_den,
    input  wire logic                     i_sat,
    input  wire logic                     i_up,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [FRACTION_BITS:0]        o_f,
    output logic                          o_up
);
    localparam int SW = SAMPLE_BITS;
    localparam int FB = FRACTION_BITS;

    logic [FB:0]   go;
    logic [FB-1:0] r_vld, r_sat, r_up;
    logic [SW-1:0] r_rem [FB];
    logic [SW-1:0] r_den [FB];
    logic [FB-1:0] r_quo [FB];
    logic [SW-1:0] src_rem [FB];
    logic [SW-1:0] src_den [FB];
    logic [FB-1:0] src_quo [FB];
    logic [SW+1:0] trial   [FB];
    logic [SW-1:0] n_rem   [FB];
    logic [FB-1:0] n_quo   [FB];

    assign go[FB]  = i_ready;
    assign o_ready = go[0];

    for (genvar k = 0; k < FB; k++) begin : g_go
        assign go[k] = !r_vld[k] || go[k+1];
    end

    always_comb begin
        for (int k = 0; k < FB; k++) begin
            if (k == 0) begin
                src_rem[k] = i_num;
                src_den[k] = i_den;
                src_quo[k] = '0;
            end else begin
                src_rem[k] = r_rem[k-1];
                src_den[k] = r_den[k-1];
                src_quo[k] = r_quo[k-1];
            end
            trial[k] = {1'b0, src_rem[k], 1'b0} - {2'b00, src_den[k]};
            if (trial[k][SW+1]) begin
                n_rem[k] = src_rem[k] << 1;
                n_quo[k] = src_quo[k] << 1;
            end else begin
                n_rem[k] = trial[k][SW-1:0];
                n_quo[k] = (src_quo[k] << 1) | FB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < FB; k++) begin
                if (go[k]) r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < FB; k++) begin
            if (go[k]) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= src_den[k];
                r_quo[k] <= n_quo[k];
                r_sat[k] <= (k == 0) ? i_sat : r_sat[k-1];
                r_up[k]  <= (k == 0) ? i_up  : r_up[k-1];
            end
        end
    end

    assign o_valid = r_vld[FB-1];
    assign o_f     = r_sat[FB-1] ? {1'b1, {FB{1'b0}}} : {1'b0, r_quo[FB-1]};
    assign o_up    = r_up[FB-1];

    `ACM_ASSERT_IMP(a_rem_below_den, i_clk, i_rst_n, r_vld[FB-1] && !r_sat[FB-1], r_rem[FB-1] < r_den[FB-1])

endmodule
`default_nettype wire

// File: rtl/acm_expo.sv
// Expo stages: square, cube, percent blend and divide by one hundred.
`default_nettype none
`include "axis_calibration_mapper_assert.svh"
module acm_expo import acm_pkg::*; #(
    parameter int FRACTION_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_mode                i_mode,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [FRACTION_BITS:0] i_f,
    input  wire logic                 i_up,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [FRACTION_BITS:0]    o_g,
    output logic                      o_up
);
    localparam int FB = FRACTION_BITS;
    localparam int FW = FB + 1;
    localparam int XW = FB + 7;
    localparam int MW = XW - 6;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << XW) / 64'(EXPO_FULL));

    logic [5:0]       go;
    logic [4:0]       r_vld, r_up;
    logic [6:0]       e_cl, e_inv;
    logic [2*FW-1:0]  sq, cube;
    logic [XW+MW-1:0] prod_q;
    logic [XW-1:0]    blend, rem_c;
    logic [FW-1:0]    r_f0, r_f2, r_f1, r_f3, r_q3, r_g;
    logic [XW-1:0]    r_x, r_x3;

    assign go[5]   = i_ready;
    assign o_ready = go[0];

    for (genvar k = 0; k < 5; k++) begin : g_go
        assign go[k] = !r_vld[k] || go[k+1];
    end

    always_comb begin
        e_cl   = (i_mode.expo_percent > EXPO_FULL) ? EXPO_FULL : i_mode.expo_percent;
        e_inv  = EXPO_FULL - e_cl;
        sq     = (2*FW)'(i_f) * (2*FW)'(i_f);
        cube   = (2*FW)'(r_f2) * (2*FW)'(r_f0);
        blend  = XW'(e_inv) * XW'(r_f1) + XW'(e_cl) * XW'(r_f3);
        prod_q = (XW+MW)'(r_x) * (XW+MW)'(RECIP);
        rem_c  = r_x3 - XW'(r_q3) * XW'(EXPO_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < 5; k++) begin
                if (go[k]) r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 5; k++) begin
            if (go[k]) r_up[k] <= (k == 0) ? i_up : r_up[k-1];
        end
        if (go[0]) begin
            r_f0 <= i_f;
            r_f2 <= sq[2*FB:FB];
        end
        if (go[1]) begin
            r_f1 <= r_f0;
            r_f3 <= cube[2*FB:FB];
        end
        if (go[2]) begin
            r_x <= blend;
        end
        if (go[3]) begin
            r_x3 <= r_x;
            r_q3 <= prod_q[XW+MW-1:XW];
        end
        if (go[4]) begin
            r_g <= (rem_c >= XW'(EXPO_FULL)) ? r_q3 + FW'(1) : r_q3;
        end
    end

    assign o_valid = r_vld[4];
    assign o_g     = r_g;
    assign o_up    = r_up[4];

    `ACM_ASSERT_IMP(a_one_correction, i_clk, i_rst_n, r_vld[3], rem_c < XW'(2) * XW'(EXPO_FULL))

endmodule
`default_nettype wire

// File: dv/axis_calibration_mapper_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the axis calibration mapper: APB setup, sample stream, value check.
module axis_calibration_mapper_tb;
    import acm_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int LATENCY      = FRAC_BITS + 9;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 400;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RAW_TOP = 4095;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    acm_sample_if #(.SAMPLE_BITS(12)) smp_bus ();
    acm_value_if                      axis_bus ();

    axis_calibration_mapper #(
        .SAMPLE_BITS  (12),
        .FRACTION_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_sample(smp_bus),
        .o_result(axis_bus)
    );

    // shadow of the calibration registers
    logic [11:0] cal_min;
    logic [11:0] cal_center;
    logic [11:0] cal_max;
    logic [11:0] cal_band;
    logic [6:0]  cal_expo;
    logic        cal_invert;
    logic        cal_linear;

    logic [11:0] raw_pending[$];
    logic [15:0] expected_axis[$];

    int n_samples;
    int n_checked;
    int n_errors;
    int n_settings;
    int n_random;
    longint cycle_count;

    int   max_gap;
    int   max_burst;
    int   stall_pct;
    int   max_hold;
    int   gap_left;
    int   burst_left;
    int   hold_left;
    logic ready_level;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned q_fraction(int num, int den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned f;
        n = longint'(num);
        d = longint'(den);
        f = (n << FRAC_BITS) / d;
        return (f > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : f;
    endfunction

    function automatic longint unsigned expo_shape(longint unsigned f);
        longint unsigned e;
        longint unsigned f2;
        longint unsigned f3;
        e  = (cal_expo > EXPO_FULL) ? longint'(EXPO_FULL) : longint'(cal_expo);
        f2 = (f * f) >> FRAC_BITS;
        f3 = (f2 * f) >> FRAC_BITS;
        return ((longint'(EXPO_FULL) - e) * f + e * f3) / longint'(EXPO_FULL);
    endfunction

    function automatic logic [15:0] mapped_axis(logic [11:0] raw);
        int r;
        int lo;
        int mid;
        int hi;
        int db;
        int span;
        int v;
        int sdb;
        int res;
        longint unsigned scaled;
        r   = int'(raw);
        lo  = int'(cal_min);
        mid = int'(cal_center);
        hi  = int'(cal_max);
        db  = int'(cal_band);
        if (cal_linear) begin
            span = hi - lo;
            if (span < 1) span = 1;
            v = r - lo;
            if (v < 0) v = 0;
            if (v > span) v = span;
            scaled = (expo_shape(q_fraction(v, span)) * longint'(K_LINEAR)) >> FRAC_BITS;
            res = int'(scaled);
        end else begin
            if (r >= mid) begin
                span = hi - mid;
                v = r - mid - db;
            end else begin
                span = mid - lo;
                v = mid - r - db;
            end
            if (span < 1) span = 1;
            if (v < 0) v = 0;
            sdb = span - db;
            if (sdb < 1) sdb = 1;
            if (r >= mid) begin
                scaled = (expo_shape(q_fraction(v, sdb)) * longint'(K_UP)) >> FRAC_BITS;
                res = int'(AXIS_MID) + int'(scaled);
            end else begin
                scaled = (expo_shape(q_fraction(v, sdb)) * longint'(K_DOWN)) >> FRAC_BITS;
                res = int'(AXIS_MID) - int'(scaled);
            end
        end
        if (res < 0) res = 0;
        if (res > 65535) res = 65535;
        if (cal_invert) res = 65535 - res;
        return res[15:0];
    endfunction

    function automatic logic [11:0] pick_sample();
        int x;
        int off;
        off = int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 7))
            3: x = int'(cal_min) + off;
            4: x = int'(cal_max) + off;
            5: x = int'(cal_center) + off;
            6: x = ($urandom_range(0, 1) != 0) ? int'(cal_center) + int'(cal_band) + off
                                              : int'(cal_center) - int'(cal_band) + off;
            7: x = ($urandom_range(0, 1) != 0) ? RAW_TOP : 0;
            default: x = int'($urandom_range(0, RAW_TOP));
        endcase
        if (x < 0) x = 0;
        if (x > RAW_TOP) x = RAW_TOP;
        return x[11:0];
    endfunction

    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [31:0] data, output logic [31:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write with junk above the field, then read it back unless the index is unused
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [11:0] value);
        logic [31:0] data;
        logic [31:0] mask;
        logic [31:0] readback;
        data = $urandom();
        case (idx)
            REG_EXPO_PERCENT:   mask = 32'h7F;
            REG_INVERT, REG_LINEAR: mask = 32'h1;
            default:            mask = 32'hFFF;
        endcase
        data = (data & ~mask) | (32'(value) & mask);
        apb_access(1'b1, idx, data, readback);
        case (idx)
            REG_RANGE_MIN:    cal_min    = data[11:0];
            REG_RANGE_CENTER: cal_center = data[11:0];
            REG_RANGE_MAX:    cal_max    = data[11:0];
            REG_DEAD_BAND:    cal_band   = data[11:0];
            REG_EXPO_PERCENT: cal_expo   = data[6:0];
            REG_INVERT:       cal_invert = data[0];
            REG_LINEAR:       cal_linear = data[0];
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            apb_access(1'b0, idx, 32'd0, readback);
            if ((readback & mask) !== (data & mask)) begin
                $display("%0t: register %0d readback mismatch, expected %0h got %0h",
                         $time, idx, data & mask, readback & mask);
                n_errors++;
            end
        end
        @(negedge i_clk);
    endtask

    task automatic randomize_setting();
        int a;
        int b;
        int c;
        int t;
        int shape;
        a = $urandom_range(0, RAW_TOP);
        b = $urandom_range(0, RAW_TOP);
        c = $urandom_range(0, RAW_TOP);
        shape = $urandom_range(0, 3);
        if (shape <= 1) begin
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
        end else if (shape == 3) begin
            a = ($urandom_range(0, 1) != 0) ? RAW_TOP : 0;
            b = ($urandom_range(0, 1) != 0) ? RAW_TOP : 0;
            c = ($urandom_range(0, 1) != 0) ? RAW_TOP : 0;
        end
        write_reg(REG_RANGE_MIN, a[11:0]);
        write_reg(REG_RANGE_CENTER, b[11:0]);
        write_reg(REG_RANGE_MAX, c[11:0]);
        case ($urandom_range(0, 3))
            0: t = 0;
            1: t = $urandom_range(0, 64);
            2: t = $urandom_range(0, RAW_TOP);
            default: t = RAW_TOP;
        endcase
        write_reg(REG_DEAD_BAND, t[11:0]);
        case ($urandom_range(0, 3))
            0: t = 0;
            1: t = int'(EXPO_FULL);
            2: t = $urandom_range(101, 127);
            default: t = $urandom_range(0, 100);
        endcase
        write_reg(REG_EXPO_PERCENT, t[11:0]);
        write_reg(REG_INVERT, 12'($urandom_range(0, 1)));
        write_reg(REG_LINEAR, 12'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 12'($urandom()));
        n_settings++;
    endtask

    task automatic set_traffic(int gap, int burst, int stall, int hold);
        max_gap   = gap;
        max_burst = burst;
        stall_pct = stall;
        max_hold  = hold;
    endtask

    // block is idle once nothing is queued, in flight or owed
    task automatic drain();
        while (raw_pending.size() != 0 || expected_axis.size() != 0 || smp_bus.valid)
            @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_bus.valid <= 1'b0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            if (smp_bus.valid && smp_bus.ready) begin
                expected_axis.push_back(mapped_axis(smp_bus.raw_sample));
                n_samples++;
            end
            if (!smp_bus.valid || smp_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    smp_bus.valid <= 1'b0;
                end else if (raw_pending.size() != 0) begin
                    smp_bus.valid      <= 1'b1;
                    smp_bus.raw_sample <= raw_pending.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, max_burst);
                        gap_left   = $urandom_range(0, max_gap);
                    end
                end else begin
                    smp_bus.valid <= 1'b0;
                end
            end
        end
    end

    // axis value monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            axis_bus.ready <= 1'b0;
            hold_left   = 0;
            ready_level = 1'b1;
        end else begin
            if (axis_bus.valid && axis_bus.ready) begin
                if (expected_axis.size() == 0) begin
                    $display("%0t: unexpected axis_value %0d, expected none",
                             $time, axis_bus.axis_value);
                    n_errors++;
                end else begin
                    logic [15:0] want;
                    want = expected_axis.pop_front();
                    n_checked++;
                    if (axis_bus.axis_value !== want) begin
                        $display("%0t: axis_value mismatch, expected %0d got %0d",
                                 $time, want, axis_bus.axis_value);
                        n_errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                ready_level = (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
                hold_left   = $urandom_range(0, max_hold);
            end
            axis_bus.ready <= ready_level;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_axis.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int count;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        smp_bus.valid      = 1'b0;
        smp_bus.raw_sample = '0;
        axis_bus.ready     = 1'b0;
        cal_min    = 12'(MIN_RESET);
        cal_center = 12'd2048;
        cal_max    = 12'd3895;
        cal_band   = 12'(BAND_RESET);
        cal_expo   = '0;
        cal_invert = 1'b0;
        cal_linear = 1'b0;
        n_samples   = 0;
        n_checked   = 0;
        n_errors    = 0;
        n_random    = 0;
        cycle_count = 0;
        set_traffic(0, 1, 0, 0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values: extremes, center goes upper side, dead band edges
        n_settings  = 1;
        raw_pending = '{12'd0, 12'd4095, 12'd2048, 12'd2047,
                        12'd2068, 12'd2069, 12'd2027, 12'd2028};
        drain();

        // linear, reversed span, expo above full, inverted
        set_traffic(3, 4, 30, 3);
        write_reg(REG_LINEAR, 12'd1);
        write_reg(REG_EXPO_PERCENT, 12'd127);
        write_reg(REG_INVERT, 12'd1);
        write_reg(REG_RANGE_MIN, 12'd3000);
        write_reg(REG_RANGE_MAX, 12'd1000);
        n_settings++;
        raw_pending = '{12'd0, 12'd999, 12'd3000, 12'd3001, 12'd4095};
        drain();

        // linear full range, full cubic
        write_reg(REG_RANGE_MIN, 12'd0);
        write_reg(REG_RANGE_MAX, 12'd4095);
        write_reg(REG_EXPO_PERCENT, 12'd100);
        write_reg(REG_INVERT, 12'd0);
        n_settings++;
        raw_pending = '{12'd0, 12'd4095, 12'd2048};
        drain();

        // centered, narrow spans so the fraction saturates; unused address ignored
        set_traffic(1, 2, 60, 6);
        write_reg(REG_LINEAR, 12'd0);
        write_reg(REG_RANGE_CENTER, 12'd2048);
        write_reg(REG_RANGE_MIN, 12'd2000);
        write_reg(REG_RANGE_MAX, 12'd2100);
        write_reg(REG_DEAD_BAND, 12'd40);
        write_reg(REG_EXPO_PERCENT, 12'd50);
        write_reg(REG_UNUSED, 12'hFFF);
        n_settings++;
        raw_pending = '{12'd4095, 12'd0, 12'd2048, 12'd2088, 12'd2089, 12'd2008, 12'd2007};
        drain();

        // center at zero, dead band wider than span
        write_reg(REG_RANGE_CENTER, 12'd0);
        write_reg(REG_DEAD_BAND, 12'd4095);
        write_reg(REG_INVERT, 12'd1);
        n_settings++;
        raw_pending = '{12'd0, 12'd4095};
        drain();

        while (n_random < RANDOM_ITEMS) begin
            randomize_setting();
            if (n_random == 0 || $urandom_range(0, 4) == 0)
                set_traffic(0, 1, 0, 0);
            else
                set_traffic($urandom_range(0, 6), $urandom_range(1, 12),
                            $urandom_range(0, 70), $urandom_range(0, 10));
            count = $urandom_range(20, 45);
            repeat (count) raw_pending.push_back(pick_sample());
            n_random += count;
            drain();
        end

        $display("covered %0d samples under %0d register settings, %0d values checked",
                 n_samples, n_settings, n_checked);
        $display("mismatches: %0d, values still owed: %0d", n_errors, expected_axis.size());
        if (n_errors == 0 && expected_axis.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
